[rtl/pcf_pkg.sv]
// Package for the pitch complementary filter unit.
// Holds widths, register indexes, controller states and the CORDIC angle table.
// No dependencies.
package pcf_pkg;

  localparam int CordicIterations = 16;
  localparam int AtanEntries = 24;
  localparam int CordicSteps = (CordicIterations < AtanEntries) ? CordicIterations : AtanEntries;
  localparam int IterW = 5;

  localparam logic signed [63:0] Deg180 = 64'sd11796480;

  localparam logic [2:0] RegBlendGain = 3'd0;
  localparam logic [2:0] RegGyroStepScale = 3'd1;
  localparam logic [2:0] RegBiasGain = 3'd2;
  localparam logic [2:0] RegAccelXOffset = 3'd3;
  localparam logic [2:0] RegAccelZOffset = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CORDIC,
    ST_MUL1,
    ST_MUL2,
    ST_OUT
  } pcf_state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic iter;
    logic mul1;
    logic mul2;
    logic commit;
  } pcf_cmd_t;

  typedef struct packed {
    logic cordic_done;
  } pcf_status_t;

  function automatic logic [21:0] atan_deg(input logic [IterW-1:0] i);
    logic [21:0] r;
    case (i)
      5'd0: r = 22'd2949120;
      5'd1: r = 22'd1740967;
      5'd2: r = 22'd919879;
      5'd3: r = 22'd466945;
      5'd4: r = 22'd234379;
      5'd5: r = 22'd117304;
      5'd6: r = 22'd58666;
      5'd7: r = 22'd29335;
      5'd8: r = 22'd14668;
      5'd9: r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] clamp180(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v < -Deg180) r = -Deg180;
    else if (v > Deg180) r = Deg180;
    else r = v;
    return r;
  endfunction

endpackage

[rtl/pcf_ctrl.sv]
// Controller state machine of the pitch complementary filter unit.
// Depends on pcf_pkg.
module pcf_ctrl import pcf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_fire,
  input  logic        out_free,
  input  pcf_status_t status,
  output pcf_cmd_t    cmd,
  output logic        busy
);

  pcf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_PREP;
      ST_PREP: state_next = ST_CORDIC;
      ST_CORDIC: if (status.cordic_done) state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_OUT;
      ST_OUT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
      end
      ST_PREP: cmd.prep = 1'b1;
      ST_CORDIC: cmd.iter = 1'b1;
      ST_MUL1: cmd.mul1 = 1'b1;
      ST_MUL2: cmd.mul2 = 1'b1;
      ST_OUT: cmd.commit = out_free;
      default: busy = 1'b1;
    endcase
  end

endmodule

[rtl/pcf_datapath.sv]
// Datapath of the pitch complementary filter unit: CORDIC, multiplies, state.
// Depends on pcf_pkg.
module pcf_datapath import pcf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  pcf_cmd_t            cmd,
  output pcf_status_t         status,
  input  logic signed [15:0]  accel_x,
  input  logic signed [15:0]  accel_z,
  input  logic signed [15:0]  gyro_y,
  input  logic [15:0]         blend_gain,
  input  logic [31:0]         gyro_step_scale,
  input  logic [31:0]         bias_gain,
  input  logic signed [19:0]  accel_x_offset,
  input  logic signed [19:0]  accel_z_offset,
  output logic signed [24:0]  pitch_angle,
  output logic signed [31:0]  bias_estimate
);

  logic signed [31:0] pitch_estimate;
  logic signed [31:0] gyro_bias;
  logic signed [15:0] last_gyro;
  logic signed [15:0] gyro_hold;
  logic signed [20:0] cx_in, cz_in;
  logic signed [31:0] cx, cy;
  logic signed [24:0] ang;
  logic [IterW-1:0]   iter;
  logic               zero_vec;
  logic signed [24:0] pred, acc;
  logic signed [63:0] pitch_mul, bias_mul;

  logic signed [48:0] diff;
  logic [48:0]        mag;
  logic [63:0]        prod;
  logic signed [63:0] delta, pred_full;
  logic signed [31:0] xs, ys;
  logic signed [63:0] acc_full, pitch_full, err, bias_full;
  logic signed [63:0] pitch_sh, bias_sh;

  assign status.cordic_done = (iter == IterW'(CordicSteps - 1));

  // The magnitude of diff always stays below 2^32, so a 32 by 32 product suffices.
  always_comb begin
    diff = (49'(last_gyro) <<< 16) - 49'(gyro_bias);
    mag = diff[48] ? 49'(-diff) : diff;
    prod = 64'(mag[31:0]) * 64'(gyro_step_scale) + 64'h80000000;
    delta = diff[48] ? -64'(prod[63:32]) : 64'(prod[63:32]);
    pred_full = clamp180(64'(pitch_estimate) + delta);
    xs = cx >>> iter;
    ys = cy >>> iter;
    acc_full = clamp180(zero_vec ? 64'sd0 : -64'(ang));
    err = 64'(acc) - 64'(pred);
    pitch_sh = (pitch_mul + 64'sd32768) >>> 16;
    pitch_full = clamp180(pitch_sh);
    bias_sh = (bias_mul + 64'sd32768) >>> 16;
    bias_full = 64'(gyro_bias) - bias_sh;
    if (bias_full > 64'sd2147483647) bias_full = 64'sd2147483647;
    else if (bias_full < -64'sd2147483648) bias_full = -64'sd2147483648;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_in <= (21'(accel_z) <<< 4) - 21'(accel_z_offset);
      cz_in <= (21'(accel_x) <<< 4) - 21'(accel_x_offset);
      gyro_hold <= gyro_y;
    end
    if (cmd.prep) begin
      zero_vec <= (cx_in == '0) && (cz_in == '0);
      iter <= '0;
      pred <= 25'(pred_full);
      if (cx_in < 0) begin
        cx <= -(32'(cx_in) <<< 8);
        cy <= -(32'(cz_in) <<< 8);
        ang <= (cz_in >= 0) ? 25'(Deg180) : -25'(Deg180);
      end else begin
        cx <= 32'(cx_in) <<< 8;
        cy <= 32'(cz_in) <<< 8;
        ang <= '0;
      end
    end
    if (cmd.iter) begin
      iter <= iter + 1'b1;
      if (cy > 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        ang <= ang + 25'(atan_deg(iter));
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        ang <= ang - 25'(atan_deg(iter));
      end
    end
    if (cmd.mul1) begin
      acc <= 25'(acc_full);
    end
    if (cmd.mul2) begin
      pitch_mul <= 64'($signed({1'b0, 17'h10000 - 17'(blend_gain)})) * 64'(pred)
                 + 64'($signed({1'b0, blend_gain})) * 64'(acc);
      bias_mul <= 64'($signed({1'b0, bias_gain})) * err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_estimate <= '0;
      gyro_bias <= '0;
      last_gyro <= '0;
    end else if (cmd.commit) begin
      pitch_estimate <= 32'(pitch_full);
      gyro_bias <= 32'(bias_full);
      last_gyro <= gyro_hold;
    end
  end

  assign pitch_angle = 25'(pitch_full);
  assign bias_estimate = 32'(bias_full);

endmodule

[rtl/pitch_complementary_filter_unit.sv]
// Pitch complementary filter unit: one IMU sample in, pitch and gyro bias out.
// Uses pcf_pkg, pcf_ctrl and pcf_datapath.
// The slave stream takes one sample per request: tdata holds accel_x, accel_z,
// gyro_y from the lowest bit up. The master stream gives pitch_angle and
// bias_estimate. The configuration channel writes registers by index while
// the unit is idle; unknown indexes are ignored.
// A request is taken only while the unit is idle. It then runs one setup
// step (ST_PREP), the 16 CORDIC iterations on a single shared shift-add stage,
// and the steps ST_MUL1 and ST_MUL2, after which the result is offered in ST_OUT.
// The result waits on the master side until taken, and the next request is
// taken in the cycle after it is handed over.
// A receiver that stalls holds the unit and its state unchanged.
// Reset loads the default gains and offsets and clears pitch, bias and the
// stored gyro sample.
module pitch_complementary_filter_unit import pcf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // accel_x, accel_z, gyro_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // pitch_angle, bias_estimate, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  pcf_cmd_t    cmd;
  pcf_status_t status;
  logic        busy, in_fire;
  logic [15:0] blend_gain;
  logic [31:0] gyro_step_scale, bias_gain;
  logic signed [19:0] accel_x_offset, accel_z_offset;
  logic signed [24:0] pitch_angle;
  logic signed [31:0] bias_estimate;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_gain <= 16'd19661;
      gyro_step_scale <= 32'd90339;
      bias_gain <= 32'd62315374;
      accel_x_offset <= 20'sd4157;
      accel_z_offset <= 20'sd12554;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegBlendGain: blend_gain <= cfg_data[15:0];
        RegGyroStepScale: gyro_step_scale <= cfg_data;
        RegBiasGain: bias_gain <= cfg_data;
        RegAccelXOffset: accel_x_offset <= cfg_data[19:0];
        RegAccelZOffset: accel_z_offset <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  pcf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(m_axis_tready),
    .status(status), .cmd(cmd), .busy(busy)
  );

  pcf_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .accel_x(s_axis_tdata[15:0]), .accel_z(s_axis_tdata[31:16]),
    .gyro_y(s_axis_tdata[47:32]),
    .blend_gain(blend_gain), .gyro_step_scale(gyro_step_scale),
    .bias_gain(bias_gain), .accel_x_offset(accel_x_offset),
    .accel_z_offset(accel_z_offset),
    .pitch_angle(pitch_angle), .bias_estimate(bias_estimate)
  );

  logic out_state;
  assign out_state = busy && !cmd.prep && !cmd.iter && !cmd.mul1 && !cmd.mul2;
  assign m_axis_tvalid = out_state;
  assign m_axis_tdata = {7'd0, bias_estimate, pitch_angle};

endmodule

[rtl/pcf_checker.sv]
// Port checker for the pitch complementary filter unit, bound to the top level.
// Depends on pcf_pkg.
module pcf_checker import pcf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("input taken while result pending");

  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid && !s_axis_tready)
    else $error("result too early");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
    else $error("not idle after delivery");

endmodule

bind pitch_complementary_filter_unit pcf_checker u_pcf_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

[tb/pitch_complementary_filter_unit_tb.sv]
// Testbench for the pitch complementary filter unit: stream samples in, compare
// pitch and bias results against a fixed-point predictor kept in a scoreboard class.
// Depends on pcf_pkg and the pitch_complementary_filter_unit RTL.
`timescale 1ns / 100ps

module pitch_complementary_filter_unit_tb import pcf_pkg::*; ;

  localparam longint AngleMax = 64'sd11796480;
  localparam int StallLimit = 5000;

  typedef struct {
    logic [24:0] pitch;
    logic [31:0] bias;
  } pitch_result_t;

  class pitch_scoreboard;
    pitch_result_t expected_q[$];
    int errors;
    logic [15:0] gain;
    logic [31:0] step_scale;
    logic [31:0] bias_gain;
    longint x_offset;
    longint z_offset;
    longint pitch_est;
    longint bias_est;
    longint prev_gyro;
    longint atan_table[24];

    function new();
      atan_table = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                     14668, 7334, 3667, 1833, 917, 458, 229, 115,
                     57, 29, 14, 7, 4, 2, 1, 0};
      errors = 0;
      gain = 16'd19661;
      step_scale = 32'd90339;
      bias_gain = 32'd62315374;
      x_offset = 4157;
      z_offset = 12554;
      pitch_est = 0;
      bias_est = 0;
      prev_gyro = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint vector_angle(longint y, longint x);
      longint ang;
      longint xs;
      longint ys;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 256;
      y = y * 256;
      if (x < 0) begin
        ang = (y >= 0) ? AngleMax : -AngleMax;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CordicSteps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          ang = ang + atan_table[i];
        end else begin
          x = x - ys;
          y = y + xs;
          ang = ang - atan_table[i];
        end
      end
      return ang;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        RegBlendGain: gain = data[15:0];
        RegGyroStepScale: step_scale = data;
        RegBiasGain: bias_gain = data;
        RegAccelXOffset: x_offset = longint'($signed(data[19:0]));
        RegAccelZOffset: z_offset = longint'($signed(data[19:0]));
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [15:0] ax, logic signed [15:0] az,
                              logic signed [15:0] gy);
      longint diff, delta, pred, acc, pitch, bias, err, kk;
      logic [63:0] mag, q;
      pitch_result_t r;
      diff = prev_gyro * 65536 - bias_est;
      mag = (diff < 0) ? -diff : diff;
      q = (mag * {32'b0, step_scale} + 64'h80000000) >> 32;
      delta = (diff < 0) ? -longint'(q) : longint'(q);
      pred = clamp(pitch_est + delta, -AngleMax, AngleMax);
      acc = -vector_angle(longint'(ax) * 16 - x_offset, longint'(az) * 16 - z_offset);
      acc = clamp(acc, -AngleMax, AngleMax);
      kk = longint'({48'b0, gain});
      pitch = ((65536 - kk) * pred + kk * acc + 32768) >>> 16;
      pitch = clamp(pitch, -AngleMax, AngleMax);
      err = acc - pred;
      bias = bias_est - ((longint'({32'b0, bias_gain}) * err + 32768) >>> 16);
      bias = clamp(bias, -64'sd2147483648, 64'sd2147483647);
      pitch_est = pitch;
      bias_est = bias;
      prev_gyro = longint'(gy);
      r.pitch = pitch[24:0];
      r.bias = bias[31:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [63:0] data);
      pitch_result_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, data);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (data[24:0] !== r.pitch) begin
        $display("%0t: pitch_angle expected %h actual %h", $time, r.pitch, data[24:0]);
        errors++;
      end
      if (data[56:25] !== r.bias) begin
        $display("%0t: bias_estimate expected %h actual %h", $time, r.bias, data[56:25]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  pitch_scoreboard board;
  int idle_cycles;
  bit hold_request;
  bit steady;

  pitch_complementary_filter_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("[pitch_complementary_filter_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] az,
                             logic signed [15:0] gy);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {gy, az, ax};
    do @(posedge clk); while (!s_axis_tready);
    board.note_sample(ax, az, gy);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.write_reg(idx, data);
  endtask

  task automatic load_setting(logic [15:0] k, logic [31:0] sc, logic [31:0] bg,
                              logic [19:0] xo, logic [19:0] zo);
    write_reg(RegBlendGain, {16'b0, k});
    write_reg(RegGyroStepScale, sc);
    write_reg(RegBiasGain, bg);
    write_reg(RegAccelXOffset, {{12{xo[19]}}, xo});
    write_reg(RegAccelZOffset, {{12{zo[19]}}, zo});
  endtask

  task automatic random_samples(int count);
    logic [15:0] ax, az, gy;
    for (int i = 0; i < count; i++) begin
      ax = 16'($urandom);
      az = 16'($urandom);
      gy = 16'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        ax = 16'($urandom_range(0, 2000) - 1000);
        az = 16'($urandom_range(0, 1000) + 3500);
        gy = 16'($urandom_range(0, 400) - 200);
      end
      send_sample(ax, az, gy);
    end
  endtask

  initial begin
    board = new();
    idle_cycles = 0;
    hold_request = 1'b0;
    steady = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(-16'sh8000, -16'sh8000, -16'sh8000);
    send_sample(16'sh7fff, -16'sh8000, 16'sh0000);
    send_sample(-16'sh8000, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh0000, 16'sh4000, -16'sh8000);
    send_sample(16'sh0100, 16'sh1000, 16'sh0010);
    wait_drained();
    load_setting(16'd0, 32'd0, 32'd0, 20'd0, 20'd0);
    send_sample(16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(16'sh0000, -16'sh0100, 16'sh0000);
    send_sample(16'sh0000, 16'sh0100, 16'sh0000);
    send_sample(16'sh0100, 16'sh0000, 16'sh0000);
    send_sample(-16'sh0100, 16'sh0000, 16'sh0000);
    send_sample(-16'sh0100, -16'sh0100, 16'sh0000);
    write_reg(3'd5, 32'hffffffff);
    write_reg(3'd6, 32'h12345678);
    write_reg(3'd7, 32'h0);
    load_setting(16'hffff, 32'hffffffff, 32'hffffffff, 20'h80000, 20'h80000);
    send_sample(16'sh7fff, -16'sh8000, 16'sh7fff);
    send_sample(-16'sh8000, 16'sh7fff, -16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh1234, -16'sh4321, 16'sh5555);

    load_setting(16'd19661, 32'd90339, 32'd62315374, 20'd4157, 20'd12554);
    random_samples(60);
    hold_request = 1'b1;
    random_samples(60);
    steady = 1'b1;
    random_samples(40);
    steady = 1'b0;
    load_setting(16'd0, 32'hffffffff, 32'hffffffff, 20'h7ffff, 20'h7ffff);
    random_samples(80);
    load_setting(16'hffff, 32'd0, 32'd0, 20'h80000, 20'h80000);
    random_samples(80);
    for (int p = 0; p < 4; p++) begin
      load_setting(16'($urandom), $urandom_range(0, 2000000), $urandom,
                   20'($urandom), 20'($urandom));
      random_samples(70);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[pitch_complementary_filter_unit] OK");
    end else begin
      $display("[pitch_complementary_filter_unit] ERROR");
    end
    $finish;
  end

endmodule
